[hw/rtl/psd_pkg.sv]
// Package for the program stream demultiplexer.
// Holds the parse phase type, the result bundle, constants and timestamp helpers.
// No dependencies.
`timescale 1ns / 1ps
package psd_pkg;

   localparam int HEADER_KEEP    = 24;
   localparam int STUFFING_LIMIT = 23;

   localparam logic [7:0] ID_PROGRAM_END = 8'hb9;
   localparam logic [7:0] ID_PACK        = 8'hba;
   localparam logic [7:0] ID_AUDIO_LO    = 8'hc0;
   localparam logic [7:0] ID_AUDIO_HI    = 8'hdf;
   localparam logic [7:0] ID_VIDEO_LO    = 8'he0;
   localparam logic [7:0] ID_VIDEO_HI    = 8'hef;
   localparam logic [7:0] VIDEO_ID_RESET = 8'he0;

   localparam logic [1:0] ROUTE_NONE  = 2'd0;
   localparam logic [1:0] ROUTE_VIDEO = 2'd1;
   localparam logic [1:0] ROUTE_AUDIO = 2'd2;

   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_PROG_END = 3'd1;
   localparam logic [2:0] EV_ES_SEEN  = 3'd2;
   localparam logic [2:0] EV_ODD_PACK = 3'd3;
   localparam logic [2:0] EV_STUFFING = 3'd4;

   typedef enum logic [3:0] {
      PH_SEARCH, PH_ID, PH_PACK, PH_SKIPLEN, PH_PES_FIXED, PH_PES2,
      PH_PES1_STUFF, PH_PES1_STD2, PH_PES1_FLAG, PH_PES1_TS, PH_PAYLOAD, PH_SKIP
   } phase_type;

   typedef struct packed {
      logic [1:0]  route;
      logic [7:0]  payload_byte;
      logic        ts_valid;
      logic        ts_is_audio;
      logic [32:0] pts;
      logic [32:0] dts;
      logic [2:0]  event_res;
   } result_type;

   function automatic logic [32:0] stamp(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [7:0] b4);
      stamp = {b0[3:1], b1, b2[7:1], b3, b4[7:1]};
   endfunction

   function automatic logic [4:0] skip_of(input logic [7:0] flag);
      case (flag[7:4])
         4'd2:    skip_of = 5'd4;
         4'd3:    skip_of = 5'd9;
         default: skip_of = 5'd0;
      endcase
   endfunction

   function automatic logic is_audio(input logic [7:0] id);
      is_audio = (id >= ID_AUDIO_LO) && (id <= ID_AUDIO_HI);
   endfunction

endpackage

[hw/rtl/program_stream_demux_unit.sv]
// Top level of the program stream demultiplexer: input register, result register
// and the video id register around psd_parser. Depends on psd_pkg.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_data_byte
//   rsp     | out       | rsp_valid, rsp_ready, rsp_route ... rsp_event_res
//   csr     | in        | csr_wr_en, csr_wr_data (video_stream_id)
//
// One byte per cycle sustained while rsp_ready stays high; the parse step sits
// between the input and result registers and writes on each advance.
// Reset is synchronous; the parser restarts its start code search.
// A stalled rsp holds the result; the input register then fills and req_ready drops.
`timescale 1ns / 1ps
module program_stream_demux_unit import psd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_route,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_ts_valid,
   output logic        rsp_ts_is_audio,
   output logic [32:0] rsp_pts,
   output logic [32:0] rsp_dts,
   output logic [2:0]  rsp_event_res,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff, step_res;
   logic [7:0] video_id_ff;
   logic       advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   psd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .data_byte (in_byte_ff),
      .video_id  (video_id_ff),
      .result    (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         video_id_ff  <= VIDEO_ID_RESET;
      end else begin
         if (req_valid && req_ready) in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
         if (csr_wr_en) video_id_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_data_byte;
      if (advance) out_ff <= step_res;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_route        = out_ff.route;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_ts_valid     = out_ff.ts_valid;
   assign rsp_ts_is_audio  = out_ff.ts_is_audio;
   assign rsp_pts          = out_ff.pts;
   assign rsp_dts          = out_ff.dts;
   assign rsp_event_res    = out_ff.event_res;

`ifndef SYNTHESIS
   a_payload_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_route != ROUTE_NONE |-> !rsp_ts_valid && rsp_event_res == EV_NONE)
      else $error("payload byte carries header result");
   a_no_stamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ts_valid |-> rsp_pts == 33'd0 && rsp_dts == 33'd0 && !rsp_ts_is_audio)
      else $error("timestamp without ts_valid");
   a_route_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_route == ROUTE_NONE |-> rsp_payload_byte == 8'd0)
      else $error("payload byte on header transaction");
`endif

endmodule

[hw/rtl/psd_parser.sv]
// Parser state and header store of the program stream demultiplexer.
// Consumes one byte per step and forms its result. Depends on psd_pkg.
`timescale 1ns / 1ps
module psd_parser import psd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] data_byte,
   input  logic [7:0] video_id,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [8:0]  cnt_ff, cnt_in;
   logic [15:0] left_ff, left_in;
   logic [23:0] win_ff, win_in;
   logic [7:0]  latch_ff, latch_in;
   logic [8:0]  tgt_ff, tgt_in;
   logic [7:0]  store_ff [HEADER_KEEP];
   logic [7:0]  view [HEADER_KEEP];

   logic        wa_req, wb_en, fin1, fin2;
   logic [8:0]  wa_idx;
   logic [7:0]  track;
   logic [4:0]  skip;
   logic        tested;
   logic [32:0] st9, st14;
   logic [17:0] rem;
   logic [7:0]  b;

   assign b = data_byte;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      win_in   = win_ff;
      latch_in = latch_ff;
      tgt_in   = tgt_ff;
      wa_req   = 1'b0;
      wa_idx   = cnt_ff;
      wb_en    = 1'b0;
      fin1     = 1'b0;
      fin2     = 1'b0;
      track    = 8'd0;
      skip     = 5'd0;
      tested   = 1'b0;
      rem      = 18'd0;
      result   = '0;
      case (phase_ff)
         PH_SEARCH: begin
            win_in = {win_ff[15:0], b};
            if (win_in == 24'h000001) phase_in = PH_ID;
         end
         PH_ID: begin
            wa_req = 1'b1;
            wa_idx = 9'd3;
            cnt_in = 9'd4;
            win_in = '1;
            if (b >= ID_VIDEO_LO && b <= ID_VIDEO_HI && video_id == 8'd0 && latch_ff == 8'd0)
               latch_in = b;
            track = (video_id != 8'd0) ? video_id : latch_in;
            if (b == ID_PROGRAM_END) begin
               result.event_res = EV_PROG_END;
               phase_in = PH_SEARCH;
            end else if (b == ID_PACK) begin
               phase_in = PH_PACK;
            end else if (is_audio(b) || (track != 8'd0 && b == track)) begin
               phase_in = PH_PES_FIXED;
            end else if (b < ID_PROGRAM_END) begin
               result.event_res = EV_ES_SEEN;
               phase_in = PH_SEARCH;
            end else begin
               phase_in = PH_SKIPLEN;
            end
         end
         PH_PACK: begin
            cnt_in = cnt_ff + 9'd1;
            if (cnt_ff == 9'd4) begin
               if (b[7:6] == 2'b01) tgt_in = 9'd14;
               else if (b[7:4] == 4'b0010) tgt_in = 9'd12;
               else result.event_res = EV_ODD_PACK;
            end else if (cnt_ff == 9'd13 && tgt_ff == 9'd14) begin
               tgt_in = 9'd14 + {6'd0, b[2:0]};
            end
            if (result.event_res == EV_ODD_PACK || cnt_in >= tgt_in) begin
               phase_in = PH_SEARCH;
               win_in   = '1;
            end
         end
         PH_SKIPLEN: begin
            wa_req = 1'b1;
            cnt_in = cnt_ff + 9'd1;
            if (cnt_ff >= 9'd5) begin
               left_in = {store_ff[4], b};
               if (left_in == 16'd0) begin
                  phase_in = PH_SEARCH;
                  win_in   = '1;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_PES_FIXED, PH_PES1_STUFF, PH_PES1_FLAG: begin
            if (phase_ff == PH_PES_FIXED) wa_req = 1'b1;
            cnt_in = cnt_ff + 9'd1;
            tested = (cnt_ff == 9'd6) || (cnt_ff + 9'd1 < 9'(STUFFING_LIMIT));
            if (phase_ff == PH_PES_FIXED && cnt_ff < 9'd6) begin
               phase_in = PH_PES_FIXED;
            end else if (phase_ff == PH_PES_FIXED && b[7:6] == 2'b10) begin
               phase_in = PH_PES2;
            end else if (phase_ff != PH_PES1_FLAG && tested && b == 8'hff) begin
               phase_in = PH_PES1_STUFF;
            end else if (phase_ff != PH_PES1_FLAG && b[7:6] == 2'b01) begin
               if (!tested) result.event_res = EV_STUFFING;
               phase_in = PH_PES1_STD2;
            end else begin
               if (phase_ff != PH_PES1_FLAG && !tested) result.event_res = EV_STUFFING;
               wb_en = 1'b1;
               skip  = skip_of(b);
               if (skip == 5'd0) begin
                  fin1 = 1'b1;
               end else begin
                  left_in  = {11'd0, skip};
                  phase_in = PH_PES1_TS;
               end
            end
         end
         PH_PES2: begin
            wa_req = 1'b1;
            cnt_in = cnt_ff + 9'd1;
            if (cnt_ff == 9'd8) tgt_in = 9'd9 + {1'b0, b};
            if (cnt_ff >= 9'd8 && cnt_in >= tgt_in) fin2 = 1'b1;
         end
         PH_PES1_STD2: begin
            cnt_in   = cnt_ff + 9'd1;
            phase_in = PH_PES1_FLAG;
         end
         PH_PES1_TS: begin
            skip   = skip_of(store_ff[9]);
            cnt_in = cnt_ff + 9'd1;
            if (left_ff >= 16'd1 && left_ff <= {11'd0, skip}) begin
               wa_req = 1'b1;
               wa_idx = {4'd0, 5'd10 + skip - left_ff[4:0]};
            end
            if (left_ff <= 16'd1) begin
               left_in = 16'd0;
               fin1    = 1'b1;
            end else begin
               left_in = left_ff - 16'd1;
            end
         end
         PH_PAYLOAD, PH_SKIP: begin
            if (phase_ff == PH_PAYLOAD) begin
               result.route        = is_audio(store_ff[3]) ? ROUTE_AUDIO : ROUTE_VIDEO;
               result.payload_byte = b;
            end
            if (left_ff <= 16'd1) begin
               left_in  = 16'd0;
               phase_in = PH_SEARCH;
               win_in   = '1;
            end else begin
               left_in = left_ff - 16'd1;
            end
         end
         default: begin
            phase_in = PH_SEARCH;
            win_in   = '1;
         end
      endcase

      for (int i = 0; i < HEADER_KEEP; i++) begin
         view[i] = ((wa_req && wa_idx == 9'(i)) || (wb_en && i == 9)) ? b : store_ff[i];
      end
      st9  = stamp(view[9], view[10], view[11], view[12], view[13]);
      st14 = stamp(view[14], view[15], view[16], view[17], view[18]);

      if (fin1 && view[9][7:5] == 3'b001) begin
         result.ts_valid = 1'b1;
         result.pts      = st9;
         result.dts      = (view[9][7:4] == 4'b0011) ? st14 : st9;
      end
      if (fin2 && view[7][7] && view[8] >= 8'd5) begin
         result.ts_valid = 1'b1;
         result.pts      = st9;
         result.dts      = (view[7][6] && view[8] >= 8'd10) ? st14 : st9;
      end
      if (fin1 || fin2) begin
         result.ts_is_audio = result.ts_valid & is_audio(view[3]);
         rem = 18'd6 + {2'd0, view[4], view[5]} - {9'd0, cnt_in};
         if (!rem[17] && rem != 18'd0) begin
            left_in  = rem[15:0];
            phase_in = PH_PAYLOAD;
         end else begin
            phase_in = PH_SEARCH;
            win_in   = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         cnt_ff   <= '0;
         left_ff  <= '0;
         win_ff   <= '1;
         latch_ff <= '0;
         tgt_ff   <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
         win_ff   <= win_in;
         latch_ff <= latch_in;
         tgt_ff   <= tgt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         for (int i = 0; i < HEADER_KEEP; i++) begin
            store_ff[i] <= view[i];
         end
      end
   end

`ifndef SYNTHESIS
   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD || phase_ff == PH_SKIP) |-> left_ff != 16'd0)
      else $error("payload or skip phase with nothing left");
   a_latch_video: assert property (@(posedge clock) disable iff (reset)
      latch_ff != 8'd0 |-> (latch_ff >= ID_VIDEO_LO && latch_ff <= ID_VIDEO_HI))
      else $error("latched video id outside video range");
   a_latch_hold: assert property (@(posedge clock) disable iff (reset)
      $past(latch_ff) != 8'd0 && !$past(reset) |-> $stable(latch_ff))
      else $error("latched video id changed");
`endif

endmodule

[dv/tb_top.sv]
// Self-checking testbench for program_stream_demux_unit: random packetized streams
// against a byte-level scoreboard model of the parser. Depends on psd_pkg and the RTL.
`timescale 1ns / 1ps
import psd_pkg::*;

class demux_scoreboard;
   phase_type   phase;
   logic [8:0]  count;
   logic [7:0]  store [HEADER_KEEP];
   logic [15:0] left;
   logic [23:0] window;
   logic [7:0]  latched;
   logic [8:0]  target;
   logic [7:0]  video_id;
   result_type  cur;
   result_type  expected_q [$];
   int          errors;

   function new();
      phase = PH_SEARCH; count = '0; left = '0; window = '1;
      latched = '0; target = '0; video_id = VIDEO_ID_RESET; errors = 0;
      foreach (store[i]) store[i] = '0;
   endfunction

   function logic [7:0] rd(int i);
      return (i < HEADER_KEEP) ? store[i] : 8'd0;
   endfunction

   function void wr(int i, logic [7:0] b);
      if (i < HEADER_KEEP) store[i] = b;
   endfunction

   function logic audio_id(logic [7:0] id);
      return id >= ID_AUDIO_LO && id <= ID_AUDIO_HI;
   endfunction

   function logic [32:0] stamp_at(int i);
      logic [7:0] b0, b1, b2, b3, b4;
      b0 = rd(i); b1 = rd(i + 1); b2 = rd(i + 2); b3 = rd(i + 3); b4 = rd(i + 4);
      return {b0[3:1], b1, b2[7:1], b3, b4[7:1]};
   endfunction

   function int skip_len(logic [7:0] f);
      return f[7:4] == 4'd2 ? 4 : (f[7:4] == 4'd3 ? 9 : 0);
   endfunction

   function void restart();
      phase = PH_SEARCH; window = '1;
   endfunction

   function void finish_pes();
      int rem;
      rem = 6 + int'({rd(4), rd(5)}) - int'(count);
      if (cur.ts_valid) cur.ts_is_audio = audio_id(rd(3));
      if (rem > 0) begin
         left = rem[15:0]; phase = PH_PAYLOAD;
      end else restart();
   endfunction

   function void pes2_done();
      logic [7:0] f, n;
      f = rd(7); n = rd(8);
      if (f[7] && n >= 5) begin
         cur.ts_valid = 1'b1; cur.pts = stamp_at(9);
         cur.dts = (f[6] && n >= 10) ? stamp_at(14) : cur.pts;
      end
      finish_pes();
   endfunction

   function void pes1_done();
      logic [7:0] f;
      f = rd(9);
      if (f[7:5] == 3'b001) begin
         cur.ts_valid = 1'b1; cur.pts = stamp_at(9);
         cur.dts = (f[7:4] == 4'h3) ? stamp_at(14) : cur.pts;
      end
      finish_pes();
   endfunction

   function void flag_byte(logic [7:0] b);
      wr(9, b);
      if (skip_len(b) == 0) pes1_done();
      else begin
         left = 16'(skip_len(b)); phase = PH_PES1_TS;
      end
   endfunction

   function void examine(logic [7:0] b, int idx);
      logic tested;
      tested = (idx == 6) || (idx + 1 < STUFFING_LIMIT);
      if (tested && b == 8'hff) begin
         phase = PH_PES1_STUFF;
         return;
      end
      if (!tested) cur.event_res = EV_STUFFING;
      if (b[7:6] == 2'b01) phase = PH_PES1_STD2;
      else flag_byte(b);
   endfunction

   function void note_byte(logic [7:0] b);
      int idx, sk;
      logic [7:0] track;
      cur = '0;
      idx = int'(count);
      case (phase)
         PH_SEARCH: begin
            window = {window[15:0], b};
            if (window == 24'h000001) phase = PH_ID;
         end
         PH_ID: begin
            wr(3, b); count = 9'd4; window = '1;
            if (b >= ID_VIDEO_LO && b <= ID_VIDEO_HI && video_id == 0 && latched == 0)
               latched = b;
            track = (video_id != 0) ? video_id : latched;
            if (b == ID_PROGRAM_END) begin
               cur.event_res = EV_PROG_END; restart();
            end else if (b == ID_PACK) phase = PH_PACK;
            else if (audio_id(b) || (track != 0 && b == track)) phase = PH_PES_FIXED;
            else if (b < ID_PROGRAM_END) begin
               cur.event_res = EV_ES_SEEN; restart();
            end else phase = PH_SKIPLEN;
         end
         PH_PACK: begin
            count = count + 9'd1;
            if (idx == 4) begin
               if (b[7:6] == 2'b01) target = 9'd14;
               else if (b[7:4] == 4'h2) target = 9'd12;
               else begin
                  cur.event_res = EV_ODD_PACK; restart();
               end
            end else if (idx == 13 && target == 9'd14) target = 9'd14 + 9'(b[2:0]);
            if (phase == PH_PACK && count >= target) restart();
         end
         PH_SKIPLEN: begin
            wr(idx, b); count = count + 9'd1;
            if (idx >= 5) begin
               left = {rd(4), b};
               if (left == 0) restart();
               else phase = PH_SKIP;
            end
         end
         PH_PES_FIXED: begin
            wr(idx, b); count = count + 9'd1;
            if (idx >= 6) begin
               if (b[7:6] == 2'b10) phase = PH_PES2;
               else examine(b, idx);
            end
         end
         PH_PES2: begin
            wr(idx, b); count = count + 9'd1;
            if (idx == 8) target = 9'd9 + 9'(b);
            if (idx >= 8 && count >= target) pes2_done();
         end
         PH_PES1_STUFF: begin
            count = count + 9'd1; examine(b, idx);
         end
         PH_PES1_STD2: begin
            count = count + 9'd1; phase = PH_PES1_FLAG;
         end
         PH_PES1_FLAG: begin
            count = count + 9'd1; flag_byte(b);
         end
         PH_PES1_TS: begin
            sk = skip_len(rd(9));
            count = count + 9'd1;
            if (left >= 1 && left <= sk) wr(10 + sk - int'(left), b);
            if (left <= 1) begin
               left = 0; pes1_done();
            end else left = left - 16'd1;
         end
         PH_PAYLOAD: begin
            cur.route = audio_id(rd(3)) ? ROUTE_AUDIO : ROUTE_VIDEO;
            cur.payload_byte = b;
            if (left <= 1) begin
               left = 0; restart();
            end else left = left - 16'd1;
         end
         PH_SKIP: begin
            if (left <= 1) begin
               left = 0; restart();
            end else left = left - 16'd1;
         end
         default: restart();
      endcase
      expected_q.push_back(cur);
   endfunction

   function void report(string what, logic [32:0] exp_v, logic [32:0] got_v);
      errors++;
      if (errors <= 10) $display("mismatch %s: expected %0h actual %0h", what, exp_v, got_v);
   endfunction

   function void check_result(result_type got);
      result_type exp_r;
      if (expected_q.size() == 0) begin
         errors++;
         if (errors <= 10) $display("mismatch: unexpected transaction %0h", got);
         return;
      end
      exp_r = expected_q.pop_front();
      if (got.route !== exp_r.route) report("route", exp_r.route, got.route);
      if (got.payload_byte !== exp_r.payload_byte)
         report("payload_byte", exp_r.payload_byte, got.payload_byte);
      if (got.ts_valid !== exp_r.ts_valid) report("ts_valid", exp_r.ts_valid, got.ts_valid);
      if (got.ts_is_audio !== exp_r.ts_is_audio)
         report("ts_is_audio", exp_r.ts_is_audio, got.ts_is_audio);
      if (got.pts !== exp_r.pts) report("pts", exp_r.pts, got.pts);
      if (got.dts !== exp_r.dts) report("dts", exp_r.dts, got.dts);
      if (got.event_res !== exp_r.event_res)
         report("event_res", exp_r.event_res, got.event_res);
   endfunction
endclass

module tb_top;
   localparam int TOTAL_BYTES = 1350;
   localparam int STALL_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_route;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_ts_valid;
   logic        rsp_ts_is_audio;
   logic [32:0] rsp_pts;
   logic [32:0] rsp_dts;
   logic [2:0]  rsp_event_res;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   demux_scoreboard sb = new();
   int send_idle = 0;
   int recv_stall = 0;
   int bytes_sent = 0;
   int quiet = 0;
   logic [7:0] id_list [6] = '{8'he0, 8'h00, 8'hef, 8'hff, 8'hc5, 8'he3};

   always #5 clock = ~clock;

   program_stream_demux_unit dut (
      .clock, .reset, .req_valid, .req_ready, .req_data_byte,
      .rsp_valid, .rsp_ready, .rsp_route, .rsp_payload_byte, .rsp_ts_valid,
      .rsp_ts_is_audio, .rsp_pts, .rsp_dts, .rsp_event_res, .csr_wr_en, .csr_wr_data
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result('{rsp_route, rsp_payload_byte, rsp_ts_valid, rsp_ts_is_audio,
                           rsp_pts, rsp_dts, rsp_event_res});
      rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
         $display("program_stream_demux_unit regression: fail");
         $finish;
      end
   end

   task automatic send(input logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic pause_send();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      pause_send();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_video_id(input logic [7:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.video_id = v;
   endtask

   task automatic start_code(input logic [7:0] id);
      send(8'h00); send(8'h00); send(8'h01); send(id);
   endtask

   task automatic random_bytes(input int n);
      repeat (n) send(8'($urandom));
   endtask

   task automatic pack_hdr(input int form);
      logic [2:0] stuff;
      start_code(ID_PACK);
      if (form == 0) begin
         stuff = 3'($urandom);
         send({2'b01, 6'($urandom)});
         random_bytes(8);
         send({5'($urandom), stuff});
         repeat (stuff) send(8'hff);
      end else if (form == 1) begin
         send({4'h2, 4'($urandom)});
         random_bytes(7);
      end else begin
         send($urandom_range(1) ? {2'b11, 6'($urandom)} : {4'h1, 4'($urandom)});
      end
   endtask

   task automatic pes_len(input int body, output int payload);
      int len;
      payload = $urandom_range(16);
      len = body + payload;
      if ($urandom_range(9) == 0) len = $urandom_range(body);
      payload = (len > body) ? len - body : 0;
      send(8'(len >> 8)); send(8'(len));
   endtask

   task automatic pes2(input logic [7:0] id);
      int hdr, pay;
      hdr = $urandom_range(3) == 0 ? $urandom_range(12) : ($urandom_range(1) ? 5 : 10);
      start_code(id);
      pes_len(3 + hdr, pay);
      send({2'b10, 6'($urandom)});
      send({2'($urandom), 6'($urandom)});
      send(8'(hdr));
      random_bytes(hdr);
      random_bytes(pay);
   endtask

   task automatic pes1(input logic [7:0] id);
      int stuff, std, sk, pay;
      logic [7:0] flag;
      stuff = $urandom_range(5) == 0 ? $urandom_range(14, 22) : $urandom_range(3);
      std = $urandom_range(1);
      case ($urandom_range(3))
         0: flag = {4'h2, 4'($urandom)};
         1: flag = {4'h3, 4'($urandom)};
         2: flag = 8'h0f;
         default: flag = {2'b00, 6'($urandom)};
      endcase
      sk = flag[7:4] == 4'h2 ? 4 : (flag[7:4] == 4'h3 ? 9 : 0);
      start_code(id);
      pes_len(stuff + 2 * std + 1 + sk, pay);
      repeat (stuff) send(8'hff);
      if (std) begin
         send({2'b01, 6'($urandom)}); send(8'($urandom));
      end
      send(flag);
      random_bytes(sk);
      random_bytes(pay);
   endtask

   task automatic other_stream();
      int n;
      n = $urandom_range(4) == 0 ? 0 : $urandom_range(20);
      start_code($urandom_range(1) ? 8'($urandom_range(8'hbb, 8'hbf))
                                   : 8'($urandom_range(8'he0, 8'hef)));
      send(8'(n >> 8)); send(8'(n));
      random_bytes(n);
   endtask

   task automatic random_packet();
      int r;
      logic [7:0] vid;
      r = $urandom_range(99);
      vid = $urandom_range(3) == 0 ? 8'($urandom_range(8'he0, 8'hef))
                                   : (sb.video_id != 0 ? sb.video_id : 8'he0);
      if (r < 10) pack_hdr($urandom_range(2));
      else if (r < 30) pes2(8'($urandom_range(8'hc0, 8'hdf)));
      else if (r < 48) pes2(vid);
      else if (r < 60) pes1(8'($urandom_range(8'hc0, 8'hdf)));
      else if (r < 70) pes1(vid);
      else if (r < 78) other_stream();
      else if (r < 82) start_code(ID_PROGRAM_END);
      else if (r < 86) start_code(8'($urandom_range(8'hb8)));
      else random_bytes($urandom_range(1, 8));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(8'h00); send(8'hff);
      start_code(ID_PROGRAM_END);
      start_code(8'h00);
      start_code(8'hb8);
      pack_hdr(2);
      pack_hdr(0);
      drain();
      for (int p = 0; p < 6; p++) begin
         write_video_id(id_list[p]);
         send_idle  = (p % 4 == 1) ? 45 : (p % 4 == 3) ? 13 : 0;
         recv_stall = (p % 4 == 2) ? 45 : (p % 4 == 3) ? 13 : 0;
         while (bytes_sent < TOTAL_BYTES * (p + 1) / 6) random_packet();
         drain();
      end
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("program_stream_demux_unit regression: pass");
      else
         $display("program_stream_demux_unit regression: fail");
      $finish;
   end
endmodule
